### hdl/imap_rf_pkg.sv
// ----------------------------------------------------------------------------
// IMAP response framer package
// Shared constants and types for the response framer: character codes,
// the literal count width and the per-byte flag group.
// ----------------------------------------------------------------------------
package imap_rf_pkg;

    localparam int COUNT_BITS = 32;

    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic length_overflow;
        logic literal_data;
        logic literal_start;
        logic response_end;
    } t_flags;

endpackage

### hdl/imap_rf_scan.sv
// ----------------------------------------------------------------------------
// IMAP response framer scanner
// Holds the framing state and works out the flags of one byte. The state
// moves on only when the byte is handed on to the result register.
// ----------------------------------------------------------------------------
module imap_rf_scan import imap_rf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    output t_flags     o_flags
);

    logic   r_after_cr, r_brace_open, r_have_digit, r_count_ovf;
    logic   r_marker_ready, r_marker_cr;
    t_count r_count, r_lit_rem;

    logic   n_after_cr, n_brace_open, n_have_digit, n_count_ovf;
    logic   n_marker_ready, n_marker_cr;
    t_count n_count, n_lit_rem;

    t_flags                flags;
    logic [COUNT_BITS+3:0] count_next;
    logic                  is_digit;

    assign is_digit   = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign count_next = ({4'b0, r_count} << 3) + ({4'b0, r_count} << 1)
                        + {{COUNT_BITS{1'b0}}, i_byte[3:0]};

    always_comb begin
        n_after_cr     = r_after_cr;
        n_brace_open   = r_brace_open;
        n_have_digit   = r_have_digit;
        n_count_ovf    = r_count_ovf;
        n_marker_ready = r_marker_ready;
        n_marker_cr    = r_marker_cr;
        n_count        = r_count;
        n_lit_rem      = r_lit_rem;
        flags          = '0;
        priority if (r_lit_rem != '0) begin
            flags.literal_data = 1'b1;
            n_lit_rem          = r_lit_rem - t_count'(1);
            n_after_cr         = 1'b0;
            n_brace_open       = 1'b0;
            n_have_digit       = 1'b0;
            n_marker_ready     = 1'b0;
            n_marker_cr        = 1'b0;
        end else if (r_after_cr && (i_byte == CH_LF)) begin
            if (r_marker_cr) begin
                if (r_count_ovf) begin
                    flags.length_overflow = 1'b1;
                    flags.response_end    = 1'b1;
                end else if (r_count != '0) begin
                    flags.literal_start = 1'b1;
                    n_lit_rem           = r_count;
                end
            end else begin
                flags.response_end = 1'b1;
            end
            n_after_cr     = 1'b0;
            n_brace_open   = 1'b0;
            n_have_digit   = 1'b0;
            n_marker_ready = 1'b0;
            n_marker_cr    = 1'b0;
        end else begin
            n_after_cr = (i_byte == CH_CR);
            priority if (i_byte == CH_LBRACE) begin
                n_brace_open   = 1'b1;
                n_have_digit   = 1'b0;
                n_marker_ready = 1'b0;
                n_marker_cr    = 1'b0;
                n_count        = '0;
                n_count_ovf    = 1'b0;
            end else if (r_brace_open && is_digit) begin
                n_have_digit = 1'b1;
                if (!r_count_ovf) begin
                    if (count_next[COUNT_BITS+3:COUNT_BITS] != 4'd0) begin
                        n_count_ovf = 1'b1;
                    end else begin
                        n_count = count_next[COUNT_BITS-1:0];
                    end
                end
            end else if (r_brace_open && r_have_digit && (i_byte == CH_RBRACE)) begin
                n_brace_open   = 1'b0;
                n_have_digit   = 1'b0;
                n_marker_ready = 1'b1;
                n_marker_cr    = 1'b0;
            end else if (r_marker_ready && (i_byte == CH_CR)) begin
                n_marker_ready = 1'b0;
                n_marker_cr    = 1'b1;
            end else begin
                n_brace_open   = 1'b0;
                n_have_digit   = 1'b0;
                n_marker_ready = 1'b0;
                n_marker_cr    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_cr     <= 1'b0;
            r_brace_open   <= 1'b0;
            r_have_digit   <= 1'b0;
            r_count_ovf    <= 1'b0;
            r_marker_ready <= 1'b0;
            r_marker_cr    <= 1'b0;
            r_count        <= '0;
            r_lit_rem      <= '0;
        end else if (i_en) begin
            r_after_cr     <= n_after_cr;
            r_brace_open   <= n_brace_open;
            r_have_digit   <= n_have_digit;
            r_count_ovf    <= n_count_ovf;
            r_marker_ready <= n_marker_ready;
            r_marker_cr    <= n_marker_cr;
            r_count        <= n_count;
            r_lit_rem      <= n_lit_rem;
        end
    end

    assign o_flags = flags;

    a_literal_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lit_rem != '0) |-> (flags.literal_data && !flags.response_end
                               && !flags.literal_start))
        else $error("literal byte carries framing flags");

    a_literal_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && flags.literal_start) |=> (r_lit_rem != '0))
        else $error("literal start left no bytes to pass");

    a_overflow_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flags.length_overflow |-> (flags.response_end && !flags.literal_start))
        else $error("overflow without response end");

    a_marker_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_marker_ready || r_marker_cr) |-> !r_brace_open)
        else $error("marker complete while brace still open");

endmodule

### hdl/imap_response_framer_unit.sv
// Path: an accepted byte waits in the input register and is loaded into the result
// register when that is empty or its result is taken; the result transfer follows.
// Throughput: one byte per cycle while results are taken; the slave is ready while the
// input register is empty or its byte moves on to the result register in the same cycle.
// Reset: synchronous, active low; clears all framing state and both valid flags,
// and no clearing pass is needed.
// ----------------------------------------------------------------------------
// IMAP response framer
// Flags response ends, literal starts and data, and overflows in an IMAP byte stream,
// one byte per transfer, through an input register, the scanner and a result register.
// ----------------------------------------------------------------------------
module imap_response_framer_unit import imap_rf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] byte_out
    output logic [3:0] o_m_axis_tuser    // [0] response_end, [1] literal_start,
                                         // [2] literal_data, [3] length_overflow
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_flags     r_out_flags;

    logic   advance;
    logic   in_ready;
    t_flags flags;

    assign advance  = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign in_ready = !r_in_valid || advance;

    imap_rf_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_byte  (r_in_byte),
        .o_flags (flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (advance) begin
            r_out_byte  <= r_in_byte;
            r_out_flags <= flags;
        end
    end

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = r_out_flags;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMAP response framer testbench
// Drives byte streams into the framer through its slave side and checks every
// result transfer against a byte-level scanner kept in the testbench. Directed
// streams cover plain lines, literals, zero counts, empty braces, overflowing
// counts and restarted markers; random responses follow, with noise and
// broken markers, while both sides stall at random outside a steady stretch.
// ----------------------------------------------------------------------------
module testbench;
    import imap_rf_pkg::*;

    localparam int RANDOM_BYTES = 900;
    localparam int PRINT_LIMIT  = 40;
    localparam int DEC_BASE     = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_PCT    = 16;
    localparam int TIMEOUT_NS   = 2000000;

    typedef logic [COUNT_BITS+3:0] t_wide_count;

    typedef struct packed {
        logic [7:0] data;
        t_flags     flags;
    } t_framed_byte;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata  = 8'd0;   // [7:0] data_byte
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;           // [7:0] byte_out
    logic [3:0] o_m_axis_tuser;           // [0] response_end, [1] literal_start,
                                          // [2] literal_data, [3] length_overflow

    t_framed_byte framed_q[$];
    int  mismatch_count = 0;
    bit  steady_flow    = 1'b0;

    int  bytes_sent     = 0;
    int  ends_seen      = 0;
    int  literals_seen  = 0;
    int  lit_bytes_seen = 0;
    int  overflows_seen = 0;

    logic   scan_after_cr      = 1'b0;
    logic   scan_brace_open    = 1'b0;
    logic   scan_have_digit    = 1'b0;
    t_count scan_count         = '0;
    logic   scan_count_ovf     = 1'b0;
    logic   scan_marker_ready  = 1'b0;
    logic   scan_marker_cr     = 1'b0;
    t_count scan_lit_left      = '0;

    imap_response_framer_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= STALL_PCT);
    end

    function automatic void drop_marker();
        scan_brace_open   = 1'b0;
        scan_have_digit   = 1'b0;
        scan_marker_ready = 1'b0;
        scan_marker_cr    = 1'b0;
    endfunction

    function automatic t_flags frame_byte(input logic [7:0] b);
        t_flags      f;
        t_wide_count wide_count;
        f = '0;
        if (scan_lit_left != '0) begin
            f.literal_data = 1'b1;
            scan_lit_left  = scan_lit_left - t_count'(1);
            scan_after_cr  = 1'b0;
            drop_marker();
        end else if (scan_after_cr && b == CH_LF) begin
            if (scan_marker_cr) begin
                if (scan_count_ovf) begin
                    f.length_overflow = 1'b1;
                    f.response_end    = 1'b1;
                end else if (scan_count != '0) begin
                    f.literal_start = 1'b1;
                    scan_lit_left   = scan_count;
                end
            end else begin
                f.response_end = 1'b1;
            end
            scan_after_cr = 1'b0;
            drop_marker();
        end else begin
            scan_after_cr = (b == CH_CR);
            if (b == CH_LBRACE) begin
                drop_marker();
                scan_brace_open = 1'b1;
                scan_count      = '0;
                scan_count_ovf  = 1'b0;
            end else if (scan_brace_open && b >= CH_ZERO && b <= CH_NINE) begin
                scan_have_digit = 1'b1;
                if (!scan_count_ovf) begin
                    wide_count = {4'b0, scan_count};
                    wide_count = wide_count * t_wide_count'(DEC_BASE)
                                 + t_wide_count'(b - CH_ZERO);
                    if (wide_count[COUNT_BITS+3:COUNT_BITS] != '0) begin
                        scan_count_ovf = 1'b1;
                    end else begin
                        scan_count = wide_count[COUNT_BITS-1:0];
                    end
                end
            end else if (scan_brace_open && scan_have_digit && b == CH_RBRACE) begin
                scan_brace_open   = 1'b0;
                scan_have_digit   = 1'b0;
                scan_marker_ready = 1'b1;
                scan_marker_cr    = 1'b0;
            end else if (scan_marker_ready && b == CH_CR) begin
                scan_marker_ready = 1'b0;
                scan_marker_cr    = 1'b1;
            end else begin
                drop_marker();
            end
        end
        return f;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic compare_flag(input string name, input logic got, input logic want,
                                input logic [7:0] b);
        if (got !== want) begin
            report_mismatch($sformatf("byte %02h: %s is %b, expected %b",
                                      b, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_framed_byte want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (framed_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer with byte %02h",
                                          o_m_axis_tdata));
            end else begin
                want = framed_q.pop_front();
                if (o_m_axis_tdata !== want.data) begin
                    report_mismatch($sformatf("byte_out is %02h, expected %02h",
                                              o_m_axis_tdata, want.data));
                end
                compare_flag("response_end", o_m_axis_tuser[0],
                             want.flags.response_end, want.data);
                compare_flag("literal_start", o_m_axis_tuser[1],
                             want.flags.literal_start, want.data);
                compare_flag("literal_data", o_m_axis_tuser[2],
                             want.flags.literal_data, want.data);
                compare_flag("length_overflow", o_m_axis_tuser[3],
                             want.flags.length_overflow, want.data);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        t_framed_byte item;
        while (!steady_flow && $urandom_range(0, 99) < STALL_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        item.data  = b;
        item.flags = frame_byte(b);
        framed_q.push_back(item);
        bytes_sent++;
        ends_seen      += item.flags.response_end;
        literals_seen  += item.flags.literal_start;
        lit_bytes_seen += item.flags.literal_data;
        overflows_seen += item.flags.length_overflow;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_byte(s[k]);
        end
    endtask

    task automatic send_crlf();
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_random_text(input int n);
        for (int k = 0; k < n; k++) begin
            send_byte(8'($urandom_range(32, 122)));
        end
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (framed_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_plain_lines();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_crlf();
        send_text("A");
        send_byte(CH_CR);
        send_crlf();
        wait_drained();
    endtask

    task automatic test_literal();
        send_text("{2}");
        send_crlf();
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_crlf();
        wait_drained();
    endtask

    task automatic test_zero_and_empty();
        send_text("{0}");
        send_crlf();
        send_text("{}");
        send_crlf();
    endtask

    task automatic test_overflow_and_restart();
        send_text("{4294967296}");
        send_crlf();
        send_text("{{1}");
        send_crlf();
        send_byte(CH_LBRACE);
        wait_drained();
    endtask

    task automatic send_marker_response();
        int    count;
        int    pick;
        string digits;
        send_random_text($urandom_range(0, 8));
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            send_random_text($urandom_range(0, 6));
            send_crlf();
            return;
        end
        if (pick < 36) begin
            digits = "9";
            repeat ($urandom_range(9, 10)) begin
                digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
            end
            send_text({"{", digits, "}"});
            send_crlf();
            return;
        end
        if (pick < 44)      count = 0;
        else if (pick < 80) count = $urandom_range(1, 12);
        else if (pick < 97) count = $urandom_range(13, 60);
        else                count = $urandom_range(200, 400);
        send_text($sformatf("{%0d}", count));
        send_crlf();
        repeat (count) send_byte(8'($urandom_range(0, 255)));
        send_random_text($urandom_range(0, 6));
        send_crlf();
    endtask

    task automatic send_broken_sequence();
        case ($urandom_range(0, 5))
            0: begin
                send_text("{12}");
                send_byte(CH_LF);
            end
            1: begin
                send_text("{7x}");
                send_crlf();
            end
            2: begin
                send_text("}");
                send_crlf();
            end
            3: begin
                send_text("{3}");
                send_byte(CH_CR);
                send_text("A");
                send_byte(CH_LF);
            end
            4: begin
                send_text("{{5");
                send_crlf();
            end
            default: begin
                send_byte(CH_CR);
                send_crlf();
            end
        endcase
    endtask

    task automatic test_random_responses();
        int first;
        int kind;
        bit drained;
        first   = bytes_sent;
        drained = 1'b0;
        while (bytes_sent - first < RANDOM_BYTES) begin
            steady_flow = (bytes_sent - first >= 400) && (bytes_sent - first < 560);
            if (!drained && bytes_sent - first >= 700) begin
                wait_drained();
                drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                send_marker_response();
            end else if (kind < 82) begin
                repeat ($urandom_range(1, 16)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_broken_sequence();
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_plain_lines();
        test_literal();
        test_zero_and_empty();
        test_overflow_and_restart();
        test_random_responses();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Streamed %0d bytes: %0d response ends, %0d literals (%0d literal bytes),",
                 bytes_sent, ends_seen, literals_seen, lit_bytes_seen);
        $display("%0d length overflows, %0d mismatching fields or transfers.",
                 overflows_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Run timed out with %0d results outstanding.", framed_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
